@@ rtl/mscf_pkg.sv @@
// Shared types and constants for the motor speed command framer.
`default_nettype none

package mscf_pkg;

  // Frame and field geometry
  localparam int unsigned FRAME_BYTES_DEF = 14;
  localparam int unsigned DATA_W          = 16;
  localparam int unsigned GAIN_W          = 10;
  localparam int unsigned MAG_W           = DATA_W + 1;
  localparam int unsigned PROD_W          = MAG_W + GAIN_W;
  localparam int unsigned FRAC_BITS       = 12;
  localparam int unsigned Q_W             = 10;
  localparam int unsigned APB_DW          = 32;
  localparam int unsigned APB_AW          = 3;

  // Saturation limit of a scaled value
  localparam logic [Q_W-1:0] SAT_MAX = 10'd999;

  // Register reset values
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 10'd100;
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 10'd800;

  // ASCII codes used in the frame
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PAD   = 8'h00;

  // Register indexes, taken from paddr[2]
  typedef enum logic {
    REG_ANGULAR_GAIN = 1'b0,
    REG_LINEAR_GAIN  = 1'b1
  } reg_idx_e;

  // One formatted number: up to sign plus three digits, left aligned
  typedef struct packed {
    logic [3:0][7:0] ch;
    logic [2:0]      len;
  } num_str_t;

endpackage

`default_nettype wire

@@ rtl/motor_speed_command_framer_unit.sv @@
// Top level of the motor speed command framer: scaling pipeline and byte serializer.
// The first byte is on tx_byte_o once the command has passed the pipeline and been loaded into
// the serializer, then one per cycle; new commands are taken while earlier ones are in flight.
// Reset: gains return to 100 and 800, the pipeline and serializer are emptied.
// The receiver cannot stall; tx_valid_o marks each byte for exactly one cycle.
`default_nettype none

module motor_speed_command_framer_unit
  import mscf_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // command request
  input  wire                      start,
  output logic                     busy,
  input  wire  signed [DATA_W-1:0] angular_rate_i,
  input  wire  signed [DATA_W-1:0] linear_speed_i,
  // byte stream
  output logic                     tx_valid_o,
  output logic [7:0]               tx_byte_o,
  output logic                     frame_end_o,
  // configuration
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [APB_AW-1:0]        paddr,
  input  wire  [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [GAIN_W-1:0] ang_gain_q, lin_gain_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  // Write the addressed gain, keep the low bits only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_gain_q <= ANG_GAIN_RST;
      lin_gain_q <= LIN_GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ANGULAR_GAIN: ang_gain_q <= pwdata[GAIN_W-1:0];
        REG_LINEAR_GAIN:  lin_gain_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed gain
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_ANGULAR_GAIN: prdata = APB_DW'(ang_gain_q);
      REG_LINEAR_GAIN:  prdata = APB_DW'(lin_gain_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_en, s2_en, s3_en, s4_en;
  logic ser_act_q, ser_load, ser_last;
  logic [CNT_W-1:0] ser_cnt_q;
  logic accept;

  assign ser_last = ser_act_q && (ser_cnt_q == CNT_LAST);
  assign ser_load = s4_v_q && (!ser_act_q || ser_last);
  assign s4_en    = !s4_v_q || ser_load;
  assign s3_en    = !s3_v_q || s4_en;
  assign s2_en    = !s2_v_q || s3_en;
  assign s1_en    = !s1_v_q || s2_en;
  assign busy     = !s1_en;
  assign accept   = start && !busy;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= accept;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
      if (s4_en) s4_v_q <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: magnitude times gain (lane 0 angular, lane 1 linear)
  logic [1:0][DATA_W-1:0] raw;
  logic [1:0][GAIN_W-1:0] gain;
  logic [1:0][MAG_W-1:0]  mag;
  logic [1:0][PROD_W-1:0] prod_q;
  logic [1:0]             s1_neg_q;

  assign raw[0]  = angular_rate_i;
  assign raw[1]  = linear_speed_i;
  assign gain[0] = ang_gain_q;
  assign gain[1] = lin_gain_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i] = raw[i][DATA_W-1] ? (MAG_W'(1) << DATA_W) - {1'b0, raw[i]} : {1'b0, raw[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && accept) begin
      for (int i = 0; i < 2; i++) begin
        prod_q[i]   <= PROD_W'(mag[i]) * PROD_W'(gain[i]);
        s1_neg_q[i] <= raw[i][DATA_W-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale down, saturate, hundreds digit
  logic [1:0][PROD_W-FRAC_BITS-1:0] q_raw;
  logic [1:0][Q_W-1:0]              q_sat;
  logic [1:0][15:0]                 h_mul;
  logic [1:0][Q_W-1:0]              q2_q;
  logic [1:0][3:0]                  h2_q;
  logic [1:0]                       s2_neg_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q_raw[i] = prod_q[i][PROD_W-1:FRAC_BITS];
      q_sat[i] = (q_raw[i] > (PROD_W-FRAC_BITS)'(SAT_MAX)) ? SAT_MAX : q_raw[i][Q_W-1:0];
      // q / 100 as q * 41 / 4096, exact below 1000
      h_mul[i] = 16'(q_sat[i]) * 16'd41;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      for (int i = 0; i < 2; i++) begin
        q2_q[i]     <= q_sat[i];
        h2_q[i]     <= h_mul[i][15:12];
        s2_neg_q[i] <= s1_neg_q[i] && (q_sat[i] != '0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: tens and ones digits, format each number

  // Lay out sign and digits left aligned, no leading zeros
  function automatic num_str_t fmt_num(input logic       neg,
                                       input logic       ge100,
                                       input logic       ge10,
                                       input logic [3:0] h,
                                       input logic [3:0] t,
                                       input logic [3:0] o);
    num_str_t   s;
    logic [1:0] p;
    s    = '0;
    p    = '0;
    if (neg) begin
      s.ch[p] = CH_MINUS;
      p       = p + 2'd1;
    end
    if (ge100) begin
      s.ch[p] = CH_ZERO + 8'(h);
      p       = p + 2'd1;
    end
    if (ge10) begin
      s.ch[p] = CH_ZERO + 8'(t);
      p       = p + 2'd1;
    end
    s.ch[p] = CH_ZERO + 8'(o);
    s.len   = 3'(p) + 3'd1;
    return s;
  endfunction

  logic [1:0][Q_W-1:0] rem_w;
  logic [1:0][6:0]     rem;
  logic [1:0][14:0]    t_mul;
  logic [1:0][3:0]     tens, ones;
  num_str_t [1:0]      str_d, str_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_w[i] = q2_q[i] - Q_W'(h2_q[i]) * Q_W'(100);
      rem[i]   = rem_w[i][6:0];
      // r / 10 as r * 205 / 2048, exact below 100
      t_mul[i] = 15'(rem[i]) * 15'd205;
      tens[i]  = t_mul[i][14:11];
      ones[i]  = 4'(rem[i] - 7'(tens[i]) * 7'd10);
      str_d[i] = fmt_num(s2_neg_q[i], q2_q[i] >= Q_W'(100), q2_q[i] >= Q_W'(10),
                         h2_q[i], tens[i], ones[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_v_q) str_q <= str_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: assemble the frame
  logic [FRAME_BYTES-1:0][7:0] frame_d, frame_q;
  logic [5:0] a_sp, b_beg, b_sp;

  assign a_sp  = 6'd3 + 6'(str_q[0].len);
  assign b_beg = a_sp + 6'd1;
  assign b_sp  = b_beg + 6'(str_q[1].len);

  always_comb begin
    for (int k = 0; k < FRAME_BYTES; k++) begin
      if (k == 0)                      frame_d[k] = CH_BANG;
      else if (k == 1)                 frame_d[k] = CH_M;
      else if (k == 2)                 frame_d[k] = CH_SPACE;
      else if (6'(k) < a_sp)           frame_d[k] = str_q[0].ch[2'(6'(k) - 6'd3)];
      else if (6'(k) == a_sp)          frame_d[k] = CH_SPACE;
      else if (6'(k) < b_sp)           frame_d[k] = str_q[1].ch[2'(6'(k) - b_beg)];
      else if (6'(k) == b_sp)          frame_d[k] = CH_SPACE;
      else if (6'(k) == b_sp + 6'd1)   frame_d[k] = CH_CR;
      else                             frame_d[k] = CH_PAD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_en && s3_v_q) frame_q <= frame_d;
  end

  // ---------------------------------------------------------------------------
  // Serializer: shift one byte out per cycle
  logic [FRAME_BYTES-1:0][7:0] ser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_act_q <= 1'b0;
      ser_cnt_q <= '0;
    end else if (ser_load) begin
      ser_act_q <= 1'b1;
      ser_cnt_q <= '0;
    end else if (ser_last) begin
      ser_act_q <= 1'b0;
      ser_cnt_q <= '0;
    end else if (ser_act_q) begin
      ser_cnt_q <= ser_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load)       ser_q <= frame_q;
    else if (ser_act_q) ser_q <= ser_q >> 8;
  end

  assign tx_valid_o  = ser_act_q;
  assign tx_byte_o   = ser_q[0];
  assign frame_end_o = ser_last;

`ifndef SYNTHESIS
  // A frame never ends twice in a row
  a_end_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end_o |=> !frame_end_o)
    else $error("frame_end on consecutive cycles");

  // Bytes of a frame come on consecutive cycles
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && !frame_end_o) |=> tx_valid_o)
    else $error("gap inside a frame");

  // Every frame opens with the start character
  a_frame_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ser_act_q) |-> (tx_byte_o == CH_BANG))
    else $error("frame does not start with bang");

  // Busy only while every pipeline stage holds a stalled command
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (s1_v_q && s2_v_q && s3_v_q && s4_v_q))
    else $error("busy with room in the pipeline");

  // A loaded frame starts right after the previous one ends
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_end_o && s4_v_q) |=> (tx_valid_o && ser_cnt_q == '0))
    else $error("pending frame not loaded on frame end");
`endif

endmodule

`default_nettype wire

@@ tb/sv/motor_speed_command_framer_unit_tb.sv @@
// Self-checking testbench for the motor speed command framer unit.
`default_nettype none

module motor_speed_command_framer_unit_tb
  import mscf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN = FRAME_BYTES_DEF;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [DATA_W-1:0] ang;
    logic [DATA_W-1:0] lin;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_exp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [DATA_W-1:0] angular_rate_i = '0;
  logic [DATA_W-1:0] linear_speed_i = '0;
  logic              tx_valid_o;
  logic [7:0]        tx_byte_o;
  logic              frame_end_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Requests waiting for the driver, and frame bytes waiting for the monitor
  cmd_t    pending_cmds[$];
  tx_exp_t frame_bytes_q[$];
  cmd_t    cur_cmd = '0;
  tx_exp_t want;
  logic    steady = 1'b0;
  int unsigned mismatch_count = 0;

  // Local copy of the gain registers
  logic [GAIN_W-1:0] ang_gain_m = ANG_GAIN_RST;
  logic [GAIN_W-1:0] lin_gain_m = LIN_GAIN_RST;

  motor_speed_command_framer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .angular_rate_i (angular_rate_i),
    .linear_speed_i (linear_speed_i),
    .tx_valid_o     (tx_valid_o),
    .tx_byte_o      (tx_byte_o),
    .frame_end_o    (frame_end_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, exp_val);
    end
    mismatch_count++;
  endtask

  // Scale one Q4.12 value by its gain, truncate toward zero, clamp, and spell it out
  function automatic num_str_t format_scaled(logic [DATA_W-1:0] raw, logic [GAIN_W-1:0] gain);
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [14:0]       q;
    num_str_t          s;
    mag  = raw[DATA_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    prod = PROD_W'(mag) * PROD_W'(gain);
    q    = prod[PROD_W-1:FRAC_BITS];
    if (q > 15'(SAT_MAX)) q = 15'(SAT_MAX);
    s = '0;
    // A negative value that scales to zero prints as plain zero
    if (raw[DATA_W-1] && q != 0) begin
      s.ch[s.len] = CH_MINUS;
      s.len = s.len + 3'd1;
    end
    if (q >= 100) begin
      s.ch[s.len] = CH_ZERO + 8'(q / 100);
      s.len = s.len + 3'd1;
    end
    if (q >= 10) begin
      s.ch[s.len] = CH_ZERO + 8'((q / 10) % 10);
      s.len = s.len + 3'd1;
    end
    s.ch[s.len] = CH_ZERO + 8'(q % 10);
    s.len = s.len + 3'd1;
    return s;
  endfunction

  // Build the full command frame for one request and queue its bytes
  function automatic void queue_command_frame(cmd_t c);
    logic [7:0]  fb [FRAME_LEN];
    num_str_t    a;
    num_str_t    l;
    int unsigned pos;
    tx_exp_t     e;
    a = format_scaled(c.ang, ang_gain_m);
    l = format_scaled(c.lin, lin_gain_m);
    foreach (fb[k]) fb[k] = CH_PAD;
    fb[0] = CH_BANG;
    fb[1] = CH_M;
    fb[2] = CH_SPACE;
    pos = 3;
    for (int k = 0; k < a.len; k++) begin
      fb[pos] = a.ch[k];
      pos++;
    end
    fb[pos] = CH_SPACE;
    pos++;
    for (int k = 0; k < l.len; k++) begin
      fb[pos] = l.ch[k];
      pos++;
    end
    fb[pos] = CH_SPACE;
    fb[pos + 1] = CH_CR;
    for (int k = 0; k < FRAME_LEN; k++) begin
      e.data = fb[k];
      e.last = (k == FRAME_LEN - 1);
      frame_bytes_q = {frame_bytes_q, e};
    end
  endfunction

  // Append one request to the driver queue
  function automatic void add_cmd(logic [DATA_W-1:0] ang, logic [DATA_W-1:0] lin);
    cmd_t c;
    c.ang = ang;
    c.lin = lin;
    pending_cmds = {pending_cmds, c};
  endfunction

  // Draw a rate or speed: full range, mid and small magnitudes, or an extreme
  function automatic logic [DATA_W-1:0] pick_rate();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = DATA_W'($urandom);
      1: begin
        v = DATA_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      2: begin
        v = DATA_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          3: v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_W'(1);
      2: return '1;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // One register write: setup cycle, then access cycle until pready
  task automatic write_gain(reg_idx_e idx, logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_ANGULAR_GAIN) ang_gain_m = val[GAIN_W-1:0];
    else lin_gain_m = val[GAIN_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both gains, with junk in the unused upper bits
  task automatic set_gains(logic [GAIN_W-1:0] ang, logic [GAIN_W-1:0] lin);
    write_gain(REG_ANGULAR_GAIN, {22'($urandom), ang});
    write_gain(REG_LINEAR_GAIN, {22'($urandom), lin});
    @(negedge clk_i);
  endtask

  // Block until every request is sent and every frame byte has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start || frame_bytes_q.size() != 0);
    repeat (FRAME_LEN) @(negedge clk_i);
  endtask

  task automatic push_directed();
    add_cmd(16'h0000, 16'h0000);
    add_cmd(16'h7FFF, 16'h8000);
    add_cmd(16'h8000, 16'h7FFF);
    add_cmd(16'hFFFF, 16'h0001);
    add_cmd(16'd41, -16'd410);
    add_cmd(-16'd4096, 16'd5115);
    add_cmd(-16'd369, -16'd5120);
    add_cmd(16'd4095, -16'd4);
  endtask

  // Driver: hold a request until accepted, then advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) queue_command_frame(cur_cmd);
      if (start && busy) begin
        // hold the current request
      end else if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 12)) begin
        cur_cmd = pending_cmds.pop_front();
        start          <= 1'b1;
        angular_rate_i <= cur_cmd.ang;
        linear_speed_i <= cur_cmd.lin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed byte against the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && tx_valid_o) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch("unexpected byte", {24'd0, tx_byte_o}, '0);
      end else begin
        want = frame_bytes_q.pop_front();
        if (tx_byte_o !== want.data)
          report_mismatch("tx_byte", {24'd0, tx_byte_o}, {24'd0, want.data});
        if (frame_end_o !== want.last)
          report_mismatch("frame_end", {31'd0, frame_end_o}, {31'd0, want.last});
      end
    end
  end

  // Sequence: reset, directed frames under three gain settings, then random phases
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_directed();
    wait_drained();
    set_gains('1, '0);
    push_directed();
    wait_drained();
    set_gains('0, '1);
    push_directed();
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      set_gains(pick_gain(), pick_gain());
      steady = (p == 2);
      for (int n = 0; n < 45; n++) begin
        add_cmd(pick_rate(), pick_rate());
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up if the run stalls
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
